>>> hw/rtl/stk_pkg.sv
`timescale 1ns / 1ps

package stk_pkg;

    // Lexer mode, one-hot
    typedef enum logic [4:0] {
        MODE_SKIP    = 5'b00001,
        MODE_COMMENT = 5'b00010,
        MODE_SLASH   = 5'b00100,
        MODE_QUOTED  = 5'b01000,
        MODE_PLAIN   = 5'b10000
    } t_mode;

    // Result item kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [15:0] LINE_FIRST = 16'd1;
    localparam logic [15:0] LINE_MAX   = 16'hFFFF;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  out_char;
        logic [8:0]  token_len;
        logic [15:0] line_no;
        logic        truncated;
    } t_result;

endpackage

>>> hw/rtl/stk_if.sv
`timescale 1ns / 1ps

// Byte input channel
interface stk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// Token output channel
interface stk_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  out_char;
    logic [8:0]  token_len;
    logic [15:0] line_no;
    logic        truncated;

    modport source (output valid, output kind, output out_char, output token_len,
                    output line_no, output truncated, input ready);
    modport sink   (input valid, input kind, input out_char, input token_len,
                    input line_no, input truncated, output ready);
endinterface

>>> hw/rtl/script_tokenizer_core.sv
`timescale 1ns / 1ps

// Script tokenizer core.
// i_in carries one script byte per item plus a last_byte flag that closes the
// buffer. o_out carries result items: token characters (kind 0) and end
// markers (kind 1) with token length, line number and a truncation flag.
// Each byte is lexed in the cycle it is accepted; its zero to three result
// items land in a four-entry output queue, and when the queue was empty the
// first one is visible on o_out in the next cycle. One byte is taken per
// cycle while the queue holds at most one item, so the sustained rate is one
// byte per cycle when each byte yields at most one item and the receiver does
// not stall; a byte that yields two or three items (pending slash, final byte)
// holds later bytes back while they drain at the single output beat per cycle.
// Reset clears the lexer state (line 1, between tokens) and empties the
// queue. When the receiver stalls, the queue fills and i_in.ready drops
// once two or more items are waiting; no item is lost.
module script_tokenizer_core #(
    parameter int MAX_TOKEN = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    stk_in_if.sink       i_in,
    stk_out_if.source    o_out
);
    import stk_pkg::*;

    localparam int KeepInt = (MAX_TOKEN - 1 < 511) ? MAX_TOKEN - 1 : 511;
    localparam logic [8:0] KeepLimit = 9'(KeepInt);
    localparam int QDepth = 4;

    // Lexer state
    t_mode       r_mode, n_mode;
    logic [15:0] r_line, n_line;
    logic [8:0]  r_cc, n_cc;
    logic        r_of, n_of;

    // Output queue
    t_result     r_q [QDepth];
    t_result     n_q [QDepth];
    logic [2:0]  r_cnt, n_cnt;

    t_result     res [3];
    logic [1:0]  push_n;
    logic        in_acc, out_pop;

    assign i_in.ready = (r_cnt <= 3'd1);
    assign in_acc     = i_in.valid && i_in.ready;
    assign o_out.valid     = (r_cnt != 3'd0);
    assign out_pop         = o_out.valid && o_out.ready;
    assign o_out.kind      = r_q[0].kind;
    assign o_out.out_char  = r_q[0].out_char;
    assign o_out.token_len = r_q[0].token_len;
    assign o_out.line_no   = r_q[0].line_no;
    assign o_out.truncated = r_q[0].truncated;

    // Lex one byte: state update and up to three result items
    always_comb begin
        logic [7:0] b;
        logic       do_plain, do_between, ws;
        t_mode       m;
        logic [15:0] ln;
        logic [8:0]  c;
        logic        ov;
        logic [1:0]  n;
        b = i_in.in_byte;
        ws = (b <= CH_SPACE);
        do_plain = 1'b0;
        do_between = 1'b0;
        m = r_mode;
        ln = r_line;
        c = r_cc;
        ov = r_of;
        n = 2'd0;
        for (int i = 0; i < 3; i++) res[i] = '0;

        unique case (r_mode)
            MODE_COMMENT: begin
                if (b == CH_LF) begin
                    if (ln != LINE_MAX) ln = ln + 16'd1;
                    m = MODE_SKIP;
                end
            end
            MODE_SLASH: begin
                if (b == CH_SLASH) begin
                    m = MODE_COMMENT;
                end else begin
                    m = MODE_PLAIN;
                    c = 9'd0;
                    ov = 1'b0;
                    // keep the held slash
                    if (c < KeepLimit) begin
                        c = c + 9'd1;
                        res[n] = '{KIND_CHAR, CH_SLASH, c, ln, 1'b0};
                        n = n + 2'd1;
                    end else begin
                        ov = 1'b1;
                    end
                    do_plain = 1'b1;
                end
            end
            MODE_QUOTED: begin
                if (b == CH_QUOTE) begin
                    res[n] = '{KIND_END, 8'h00, c, ln, ov};
                    n = n + 2'd1;
                    m = MODE_SKIP;
                    c = 9'd0;
                    ov = 1'b0;
                end else if (c < KeepLimit) begin
                    c = c + 9'd1;
                    res[n] = '{KIND_CHAR, b, c, ln, 1'b0};
                    n = n + 2'd1;
                end else begin
                    ov = 1'b1;
                end
            end
            MODE_PLAIN: do_plain = 1'b1;
            default:    do_between = 1'b1;
        endcase

        // Inside a plain token
        if (do_plain) begin
            if (ws || b == CH_SEMI) begin
                res[n] = '{KIND_END, 8'h00, c, ln, ov};
                n = n + 2'd1;
                m = MODE_SKIP;
                c = 9'd0;
                ov = 1'b0;
                do_between = 1'b1;
            end else if (c < KeepLimit) begin
                c = c + 9'd1;
                res[n] = '{KIND_CHAR, b, c, ln, 1'b0};
                n = n + 2'd1;
            end else begin
                ov = 1'b1;
            end
        end

        // Between tokens
        if (do_between) begin
            m = MODE_SKIP;
            if (ws) begin
                if (b == CH_LF && ln != LINE_MAX) ln = ln + 16'd1;
            end else if (b == CH_SEMI || b == CH_HASH) begin
                m = MODE_COMMENT;
            end else if (b == CH_SLASH) begin
                m = MODE_SLASH;
            end else if (b == CH_QUOTE) begin
                m = MODE_QUOTED;
                c = 9'd0;
                ov = 1'b0;
            end else begin
                m = MODE_PLAIN;
                c = 9'd0;
                ov = 1'b0;
                if (c < KeepLimit) begin
                    c = c + 9'd1;
                    res[n] = '{KIND_CHAR, b, c, ln, 1'b0};
                    n = n + 2'd1;
                end else begin
                    ov = 1'b1;
                end
            end
        end

        // Final byte closes the buffer
        if (i_in.last_byte) begin
            if (m == MODE_PLAIN || m == MODE_QUOTED) begin
                res[n] = '{KIND_END, 8'h00, c, ln, ov};
                n = n + 2'd1;
            end else if (m == MODE_SLASH) begin
                c = 9'd0;
                ov = 1'b0;
                if (c < KeepLimit) begin
                    c = c + 9'd1;
                    res[n] = '{KIND_CHAR, CH_SLASH, c, ln, 1'b0};
                    n = n + 2'd1;
                end else begin
                    ov = 1'b1;
                end
                res[n] = '{KIND_END, 8'h00, c, ln, ov};
                n = n + 2'd1;
            end
            m = MODE_SKIP;
            ln = LINE_FIRST;
            c = 9'd0;
            ov = 1'b0;
        end

        n_mode = in_acc ? m : r_mode;
        n_line = in_acc ? ln : r_line;
        n_cc   = in_acc ? c : r_cc;
        n_of   = in_acc ? ov : r_of;
        push_n = in_acc ? n : 2'd0;
    end

    // Queue: shift on pop, append new items behind the kept ones
    always_comb begin
        logic [2:0] keep;
        logic [2:0] off;
        keep = r_cnt - {2'd0, out_pop};
        for (int i = 0; i < QDepth; i++) begin
            off = 3'(i) - keep;
            n_q[i] = r_q[i];
            if (3'(i) < keep) begin
                if (out_pop && i < QDepth - 1) n_q[i] = r_q[(i + 1) % QDepth];
            end else if (off < {1'b0, push_n}) begin
                n_q[i] = res[off[1:0]];
            end
        end
        n_cnt = keep + {1'b0, push_n};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SKIP;
            r_line <= LINE_FIRST;
            r_cc   <= 9'd0;
            r_of   <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_cc   <= n_cc;
            r_of   <= n_of;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDepth; i++) r_q[i] <= n_q[i];
    end

endmodule

>>> hw/rtl/stk_checker.sv
`timescale 1ns / 1ps

module stk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_kind,
    input logic [8:0]  i_token_len,
    input logic [15:0] i_line_no,
    input logic        i_truncated
);
    import stk_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // Input only backs off while results are waiting
    a_ready_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty output queue");

    // A character item carries a nonzero length and no truncation flag
    a_char_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_CHAR |-> i_token_len != 9'd0 && !i_truncated)
        else $error("bad character item");

    // Line numbers start at one
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_line_no != 16'd0)
        else $error("line number zero");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_kind) && $stable(i_token_len)
            && $stable(i_line_no) && $stable(i_truncated))
        else $error("result item changed while stalled");

endmodule

bind script_tokenizer_core stk_checker u_stk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.kind),
    .i_token_len (o_out.token_len),
    .i_line_no   (o_out.line_no),
    .i_truncated (o_out.truncated)
);

>>> tb/sv/tb_script_tokenizer_core.sv
`timescale 1ns / 1ps

module tb_script_tokenizer_core;
    import stk_pkg::*;

    localparam int TOK_MAX     = 512;
    // characters kept per token before truncation kicks in
    localparam int KEEP_MAX    = (TOK_MAX - 1 < 511) ? TOK_MAX - 1 : 511;
    localparam int RAND_ITEMS  = 260;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_PRINTS  = 40;

    typedef struct {
        logic [7:0] b;
        logic       last;
        int         gap;
    } t_byte_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    stk_in_if  byte_ch ();
    stk_out_if tok_ch ();

    script_tokenizer_core #(
        .MAX_TOKEN (TOK_MAX)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (tok_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pending script bytes and expected token results
    t_byte_item  pend[$];
    t_result     tok_expect[$];

    int unsigned err_cnt      = 0;
    int unsigned bytes_in     = 0;
    int unsigned results_seen = 0;
    int unsigned tokens_seen  = 0;
    int unsigned trunc_seen   = 0;
    int unsigned cycle_cnt    = 0;
    int          gen_phase    = 0;
    logic        rx_hold;

    // Lexer shadow state
    t_mode       lx_mode;
    logic [15:0] lx_line;
    logic [8:0]  lx_len;
    logic        lx_ovf;

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic int idle_gap(input int phase);
        case (phase)
            0: return 0;
            1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 12)) : 0;
            default: return int'($urandom_range(0, 12));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    task automatic lex_clear();
        lx_mode = MODE_SKIP;
        lx_line = LINE_FIRST;
        lx_len  = '0;
        lx_ovf  = 1'b0;
    endtask

    task automatic push_result(input logic kind, input logic [7:0] ch,
                               input logic [8:0] len, input logic trunc);
        t_result r;
        r.kind      = kind;
        r.out_char  = ch;
        r.token_len = len;
        r.line_no   = lx_line;
        r.truncated = trunc;
        tok_expect.push_back(r);
    endtask

    task automatic line_up();
        if (lx_line != LINE_MAX)
            lx_line = lx_line + 16'd1;
    endtask

    task automatic token_open(input t_mode m);
        lx_mode = m;
        lx_len  = '0;
        lx_ovf  = 1'b0;
    endtask

    task automatic keep_char(input logic [7:0] ch);
        if (int'(lx_len) < KEEP_MAX) begin
            lx_len = lx_len + 9'd1;
            push_result(KIND_CHAR, ch, lx_len, 1'b0);
        end else begin
            lx_ovf = 1'b1;
        end
    endtask

    task automatic token_close();
        push_result(KIND_END, 8'h00, lx_len, lx_ovf);
        token_open(MODE_SKIP);
    endtask

    // byte seen while no token is open
    task automatic gap_byte(input logic [7:0] b);
        lx_mode = MODE_SKIP;
        if (b <= CH_SPACE) begin
            if (b == CH_LF)
                line_up();
        end else if (b == CH_SEMI || b == CH_HASH) begin
            lx_mode = MODE_COMMENT;
        end else if (b == CH_SLASH) begin
            lx_mode = MODE_SLASH;
        end else if (b == CH_QUOTE) begin
            token_open(MODE_QUOTED);
        end else begin
            token_open(MODE_PLAIN);
            keep_char(b);
        end
    endtask

    task automatic plain_byte(input logic [7:0] b);
        if (b <= CH_SPACE || b == CH_SEMI) begin
            token_close();
            gap_byte(b);
        end else begin
            keep_char(b);
        end
    endtask

    task automatic lex_byte(input logic [7:0] b, input logic last);
        case (lx_mode)
            MODE_COMMENT: begin
                if (b == CH_LF) begin
                    line_up();
                    lx_mode = MODE_SKIP;
                end
            end
            MODE_SLASH: begin
                if (b == CH_SLASH) begin
                    lx_mode = MODE_COMMENT;
                end else begin
                    token_open(MODE_PLAIN);
                    keep_char(CH_SLASH);
                    plain_byte(b);
                end
            end
            MODE_QUOTED: begin
                if (b == CH_QUOTE)
                    token_close();
                else
                    keep_char(b);
            end
            MODE_PLAIN: plain_byte(b);
            default:    gap_byte(b);
        endcase

        // end of buffer: close what is open, then start over at line 1
        if (last) begin
            if (lx_mode == MODE_PLAIN || lx_mode == MODE_QUOTED) begin
                token_close();
            end else if (lx_mode == MODE_SLASH) begin
                token_open(MODE_PLAIN);
                keep_char(CH_SLASH);
                token_close();
            end
            lex_clear();
        end
    endtask

    // ------------------------------------------------------------------
    // Script generation
    // ------------------------------------------------------------------
    task automatic add_item(input logic [7:0] b, input logic last);
        t_byte_item it;
        it.b    = b;
        it.last = last;
        it.gap  = idle_gap(gen_phase);
        pend.push_back(it);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do b = 8'($urandom_range(33, 255)); while (b == CH_SEMI);
        return b;
    endfunction

    function automatic logic [7:0] any_but(input logic [7:0] avoid);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == avoid);
        return b;
    endfunction

    function automatic logic [7:0] plain_start();
        logic [7:0] b;
        do b = plain_char();
        while (b == CH_HASH || b == CH_SLASH || b == CH_QUOTE);
        return b;
    endfunction

    task automatic add_token_end();
        if ($urandom_range(0, 4) == 0)
            add_item(CH_SEMI, 1'b0);
        else
            add_item(8'($urandom_range(0, 32)), 1'b0);
    endtask

    task automatic add_segment();
        int n;
        n = int'($urandom_range(0, 12));
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                add_item(plain_start(), 1'b0);
                repeat (n) add_item(plain_char(), 1'b0);
                add_token_end();
            end
            3, 4: begin
                add_item(CH_QUOTE, 1'b0);
                repeat (n) add_item(any_but(CH_QUOTE), 1'b0);
                add_item(CH_QUOTE, 1'b0);
            end
            5: begin
                case ($urandom_range(0, 2))
                    0: add_item(CH_SEMI, 1'b0);
                    1: add_item(CH_HASH, 1'b0);
                    default: begin
                        add_item(CH_SLASH, 1'b0);
                        add_item(CH_SLASH, 1'b0);
                    end
                endcase
                repeat (n % 8) add_item(any_but(CH_LF), 1'b0);
                add_item(CH_LF, 1'b0);
            end
            6: begin
                add_item(CH_SLASH, 1'b0);
                repeat (n % 5) add_item(plain_char(), 1'b0);
                add_token_end();
            end
            7: repeat (1 + n % 3) add_item(8'($urandom_range(0, 32)), 1'b0);
            8: add_item(CH_LF, 1'b0);
            default: repeat (1 + n % 4) add_item(8'($urandom_range(0, 255)), 1'b0);
        endcase
        // now and then the buffer ends right here
        if ($urandom_range(0, 11) == 0)
            pend[pend.size() - 1].last = 1'b1;
    endtask

    task automatic build_script();
        int rand_end;
        int long_at;
        int long_len;
        bit long_done;
        bit quoted;

        // directed: token ends, all comment starters, slash handling, quotes
        add_item("A", 1'b0);      add_item(CH_SPACE, 1'b0);
        add_item(CH_SLASH, 1'b0); add_item(CH_SLASH, 1'b0);
        add_item("x", 1'b0);      add_item(CH_LF, 1'b0);
        add_item(CH_SLASH, 1'b0); add_item("q", 1'b0);
        add_item(CH_SPACE, 1'b0);
        add_item(CH_HASH, 1'b0);  add_item(CH_LF, 1'b0);
        add_item(CH_QUOTE, 1'b0); add_item(CH_QUOTE, 1'b0);
        add_item(CH_QUOTE, 1'b0); add_item(CH_LF, 1'b0);
        add_item(8'hFF, 1'b0);    add_item(CH_QUOTE, 1'b0);
        add_item(8'h80, 1'b0);    add_item(8'h00, 1'b0);
        add_item("k", 1'b0);      add_item(CH_SEMI, 1'b0);
        add_item(CH_LF, 1'b0);
        add_item(CH_SLASH, 1'b1);
        add_item(CH_QUOTE, 1'b0); add_item("m", 1'b1);

        // random script with one overlong token half way through
        rand_end  = pend.size() + RAND_ITEMS;
        long_at   = pend.size() + RAND_ITEMS / 2;
        long_done = 1'b0;
        while (pend.size() < rand_end) begin
            if ($urandom_range(0, 14) == 0)
                gen_phase = int'($urandom_range(0, 2));
            if (!long_done && pend.size() >= long_at) begin
                long_done = 1'b1;
                quoted    = 1'($urandom_range(0, 1));
                long_len  = int'($urandom_range(KEEP_MAX + 1, KEEP_MAX + 20));
                add_item(quoted ? CH_QUOTE : plain_start(), 1'b0);
                repeat (long_len)
                    add_item(quoted ? any_but(CH_QUOTE) : plain_char(), 1'b0);
                add_item(quoted ? CH_QUOTE : CH_SPACE, 1'b0);
            end else begin
                add_segment();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Byte driver
    // ------------------------------------------------------------------
    t_byte_item nxt;
    bit         staged;
    int         gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
            staged = 1'b0;
            lex_clear();
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                lex_byte(byte_ch.in_byte, byte_ch.last_byte);
                bytes_in <= bytes_in + 1;
            end
            // hold the item while it is offered and not yet taken
            if (!(byte_ch.valid && !byte_ch.ready)) begin
                if (!staged && pend.size() != 0) begin
                    nxt      = pend.pop_front();
                    staged   = 1'b1;
                    gap_left = nxt.gap;
                end
                if (staged && gap_left == 0) begin
                    byte_ch.valid     <= 1'b1;
                    byte_ch.in_byte   <= nxt.b;
                    byte_ch.last_byte <= nxt.last;
                    staged = 1'b0;
                end else begin
                    byte_ch.valid <= 1'b0;
                    if (staged)
                        gap_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off to fill the output queue
    // ------------------------------------------------------------------
    int hold_left;
    bit hold_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0)
                rx_hold <= 1'b0;
        end else if (!hold_done && bytes_in >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            rx_hold <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            tok_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (tok_ch.valid && tok_ch.ready) begin
                got.kind      = tok_ch.kind;
                got.out_char  = tok_ch.out_char;
                got.token_len = tok_ch.token_len;
                got.line_no   = tok_ch.line_no;
                got.truncated = tok_ch.truncated;
                results_seen++;
                if (got.kind == KIND_END) begin
                    tokens_seen++;
                    if (got.truncated)
                        trunc_seen++;
                end
                if (tok_expect.size() == 0) begin
                    flag_error($sformatf("unexpected item: kind %0d char %02h len %0d line %0d",
                                         got.kind, got.out_char, got.token_len, got.line_no));
                end else begin
                    want = tok_expect.pop_front();
                    if (got.kind !== want.kind)
                        flag_error($sformatf("item %0d kind %0d, want %0d",
                                             results_seen, got.kind, want.kind));
                    if (got.out_char !== want.out_char)
                        flag_error($sformatf("item %0d out_char %02h, want %02h",
                                             results_seen, got.out_char, want.out_char));
                    if (got.token_len !== want.token_len)
                        flag_error($sformatf("item %0d token_len %0d, want %0d",
                                             results_seen, got.token_len, want.token_len));
                    if (got.line_no !== want.line_no)
                        flag_error($sformatf("item %0d line_no %0d, want %0d",
                                             results_seen, got.line_no, want.line_no));
                    if (got.truncated !== want.truncated)
                        flag_error($sformatf("item %0d truncated %0d, want %0d",
                                             results_seen, got.truncated, want.truncated));
                end
                stall_left = idle_gap(int'((results_seen / 30) % 3));
            end else if (stall_left > 0) begin
                stall_left--;
            end
            tok_ch.ready <= (stall_left == 0) && !rx_hold;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d items still expected",
                 cycle_cnt, tok_expect.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial begin
        byte_ch.valid     = 1'b0;
        byte_ch.in_byte   = 8'h00;
        byte_ch.last_byte = 1'b0;
        tok_ch.ready      = 1'b0;
        i_rst_n           = 1'b0;

        build_script();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend.size() != 0 || staged || byte_ch.valid)
            @(posedge i_clk);
        while (tok_expect.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Lexed %0d script bytes into %0d output items (%0d tokens, %0d truncated)",
                 bytes_in, results_seen, tokens_seen, trunc_seen);
        $display("Covered comments, slash lookahead, quotes, buffer ends, overlong tokens");
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/stk_pkg.sv
hw/rtl/stk_if.sv
hw/rtl/script_tokenizer_core.sv
hw/rtl/stk_checker.sv
tb/sv/tb_script_tokenizer_core.sv
